// ===== sv/assert_macros.svh =====
// Assertion macros used by the filter datapath.
// Defining ASSERT_OFF turns every check into an empty statement.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHECK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_CHECK(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/hpb_pkg.sv =====
// Package for the modulated high-pass biquad: widths, register indexes,
// controller/datapath command types and the tangent table. No dependencies.
`timescale 1ns / 1ps
package hpb_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 24;
  localparam int COEF_FRAC    = 20;
  localparam int TAN_DEPTH    = 1024;
  localparam int TAN_IDX_BITS = 10;
  localparam int TAN_BITS     = 24;
  localparam int CORDIC_STEPS = 30;
  localparam int MUL_A_BITS   = 35;
  localparam int MUL_B_BITS   = 25;
  localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;
  localparam int DIV_N_BITS   = 38;
  localparam int DIV_D_BITS   = 33;
  localparam int DIV_CNT_BITS = 6;
  localparam int ACC_BITS     = 44;
  localparam int ADDR_BITS    = 5;

  localparam logic [DIV_CNT_BITS-1:0] DIV_ITERS_IDX  = 6'd26;
  localparam logic [DIV_CNT_BITS-1:0] DIV_ITERS_COEF = 6'd37;

  localparam logic [2:0] REG_DAMPING     = 3'd0;
  localparam logic [2:0] REG_OFFSET      = 3'd1;
  localparam logic [2:0] REG_MIN_FREQ    = 3'd2;
  localparam logic [2:0] REG_MAX_FREQ    = 3'd3;
  localparam logic [2:0] REG_SAMPLE_RATE = 3'd4;
  localparam logic [2:0] REG_OUT_LIMIT   = 3'd5;

  typedef enum logic [2:0] {
    MUL_MAP, MUL_RC, MUL_CC, MUL_B1, MUL_B2, MUL_F0, MUL_F1, MUL_F2
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    logic     ld_freq;
    logic     div_start;
    logic     div_coef;
    logic     ld_idx;
    logic     ld_rc;
    logic     ld_cc;
    logic     ld_a1;
    logic     ld_b1;
    logic     ld_b2;
    logic     acc_init;
    logic     acc_sub;
    logic     ld_out;
  } hpb_cmd_t;

  typedef struct packed {
    logic need_recompute;
    logic div_busy;
    logic out_free;
  } hpb_sts_t;

  typedef logic [TAN_BITS-1:0] tan_table_t [TAN_DEPTH];

  localparam longint PI_Q30  = 64'sd3373259426;
  localparam longint TAN_MAX = 64'sd16777215;

  localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  // Shift-and-subtract quotient of a non-negative value by a positive one.
  function automatic longint udiv_pos(input longint num, input longint dvs);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int i = 62; i >= 0; i--) begin
      r = (r <<< 1) | ((num >>> i) & 64'sd1);
      if (r >= dvs) begin
        r = r - dvs;
        q = q | (64'sd1 <<< i);
      end
    end
    return q;
  endfunction

  // Entry k holds tan(pi*k/(2*depth)) in Q8.16, from a rotation-mode CORDIC.
  function automatic tan_table_t build_tan_table();
    tan_table_t tab;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint t;
    for (int k = 0; k < TAN_DEPTH; k++) begin
      z = (longint'(k) * PI_Q30) / (2 * TAN_DEPTH);
      x = 64'sd1 <<< 30;
      y = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx;
          y = y + dy;
          z = z - ATAN_Q30[i];
        end else begin
          x = x + dx;
          y = y - dy;
          z = z + ATAN_Q30[i];
        end
      end
      if (y < 0) y = 0;
      if (x <= 0) begin
        t = TAN_MAX;
      end else begin
        t = udiv_pos(y * 65536, x);
        if (t > TAN_MAX) t = TAN_MAX;
      end
      tab[k] = t[TAN_BITS-1:0];
    end
    return tab;
  endfunction

  localparam tan_table_t TAN_TABLE = build_tan_table();

endpackage

// ===== sv/hpb_tan_rom.sv =====
// Tangent lookup ROM with a registered read port.
// Depends on hpb_pkg for the table contents and widths.
`timescale 1ns / 1ps
module hpb_tan_rom (
  input  logic                             clk,
  input  logic [hpb_pkg::TAN_IDX_BITS-1:0] addr,
  output logic [hpb_pkg::TAN_BITS-1:0]     data
);

  always_ff @(posedge clk) begin
    data <= hpb_pkg::TAN_TABLE[addr];
  end

endmodule

// ===== sv/hpb_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on hpb_pkg for widths. The dividend arrives left-aligned.
`timescale 1ns / 1ps
module hpb_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [hpb_pkg::DIV_N_BITS-1:0]   dividend,
  input  logic [hpb_pkg::DIV_D_BITS-1:0]   divisor,
  input  logic [hpb_pkg::DIV_CNT_BITS-1:0] iters,
  output logic                             busy,
  output logic [hpb_pkg::DIV_N_BITS-1:0]   quotient
);

  logic [hpb_pkg::DIV_D_BITS-1:0]   rem;
  logic [hpb_pkg::DIV_D_BITS-1:0]   dvs;
  logic [hpb_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [hpb_pkg::DIV_D_BITS:0]     trial;
  logic [hpb_pkg::DIV_D_BITS:0]     diff;
  logic                             qbit;

  always_comb begin
    trial = {rem, quotient[hpb_pkg::DIV_N_BITS-1]};
    diff  = trial - {1'b0, dvs};
    qbit  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[hpb_pkg::DIV_N_BITS-2:0], qbit};
      rem      <= qbit ? diff[hpb_pkg::DIV_D_BITS-1:0] : trial[hpb_pkg::DIV_D_BITS-1:0];
    end
  end

endmodule

// ===== sv/hpb_dp.sv =====
// Datapath: shared multiplier, divider, tangent ROM, coefficients, filter
// state and output register. Depends on hpb_pkg, hpb_div, hpb_tan_rom.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hpb_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  hpb_pkg::hpb_cmd_t    cmd,
  output hpb_pkg::hpb_sts_t    sts,
  input  logic signed [15:0]   audio_in,
  input  logic signed [15:0]   cutoff_mod,
  input  logic                 cfg_wr,
  input  logic [14:0]          damping,
  input  logic signed [15:0]   cutoff_offset_hz,
  input  logic [14:0]          min_frequency_hz,
  input  logic [14:0]          max_frequency_hz,
  input  logic [17:0]          sample_rate_hz,
  input  logic [14:0]          output_limit,
  output logic signed [15:0]   audio_out,
  output logic                 out_valid,
  input  logic                 out_stall
);

  logic signed [15:0] x, modv, x1, x2, y1, y2, last_mod;
  logic               pending;
  logic [14:0]        freq;
  logic [hpb_pkg::TAN_IDX_BITS-1:0] idx;
  logic [hpb_pkg::TAN_BITS-1:0]     c;
  logic [24:0]        rc;
  logic [31:0]        cc;
  logic signed [hpb_pkg::COEF_BITS-1:0] a1, b1, b2;
  logic signed [hpb_pkg::MUL_A_BITS-1:0] ma;
  logic signed [hpb_pkg::MUL_B_BITS-1:0] mb;
  logic signed [hpb_pkg::PROD_BITS-1:0]  p;
  logic signed [hpb_pkg::ACC_BITS-1:0]   acc;
  logic signed [15:0] span;
  logic signed [17:0] tap_sum;
  logic signed [34:0] cc_m1, b2_num;
  logic signed [19:0] fsum;
  logic [14:0]        freq_next;
  logic [32:0]        den;
  logic [36:0]        coef_num;
  logic [hpb_pkg::DIV_N_BITS-1:0] div_n;
  logic [hpb_pkg::DIV_D_BITS-1:0] div_d;
  logic [hpb_pkg::DIV_N_BITS-1:0] quo;
  logic               div_busy;
  logic signed [hpb_pkg::PROD_BITS-1:0] p_rnd;
  logic signed [hpb_pkg::ACC_BITS-1:0]  acc_rnd;
  logic signed [23:0] y_wide, lim;
  logic signed [15:0] y_next;

  function automatic logic signed [23:0] sat_coef(input logic signed [43:0] v);
    if (v > 44'sd8388607) return 24'sh7FFFFF;
    if (v < -44'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  assign sts.need_recompute = pending || (cutoff_mod != last_mod);
  assign sts.div_busy       = div_busy;
  assign sts.out_free       = !out_valid || !out_stall;

  // Operand selection for the one shared multiplier.
  always_comb begin
    span    = $signed({1'b0, max_frequency_hz}) - $signed({1'b0, min_frequency_hz});
    tap_sum = {{2{x[15]}}, x} - {x1[15], x1, 1'b0} + {{2{x2[15]}}, x2};
    cc_m1   = $signed({3'b0, cc}) - 35'sd65536;
    b2_num  = $signed({3'b0, cc}) - $signed({10'b0, rc}) + 35'sd65536;
    case (cmd.mul_sel)
      hpb_pkg::MUL_MAP: begin
        ma = {19'b0, ~modv[15], modv[14:0]};
        mb = {{9{span[15]}}, span};
      end
      hpb_pkg::MUL_RC: begin
        ma = {20'b0, damping};
        mb = {1'b0, c};
      end
      hpb_pkg::MUL_CC: begin
        ma = {11'b0, c};
        mb = {1'b0, c};
      end
      hpb_pkg::MUL_B1: begin
        ma = {cc_m1[33:0], 1'b0};
        mb = {a1[23], a1};
      end
      hpb_pkg::MUL_B2: begin
        ma = b2_num;
        mb = {a1[23], a1};
      end
      hpb_pkg::MUL_F0: begin
        ma = {{17{tap_sum[17]}}, tap_sum};
        mb = {a1[23], a1};
      end
      hpb_pkg::MUL_F1: begin
        ma = {{19{y1[15]}}, y1};
        mb = {b1[23], b1};
      end
      hpb_pkg::MUL_F2: begin
        ma = {{19{y2[15]}}, y2};
        mb = {b2[23], b2};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  // Mapped frequency plus offset, then the lower clamp is tested first.
  always_comb begin
    fsum = p[35:16] + $signed({5'b0, min_frequency_hz})
         + $signed({{4{cutoff_offset_hz[15]}}, cutoff_offset_hz});
    if (fsum < $signed({5'b0, min_frequency_hz})) begin
      freq_next = min_frequency_hz;
    end else if (fsum > $signed({5'b0, max_frequency_hz})) begin
      freq_next = max_frequency_hz;
    end else begin
      freq_next = fsum[14:0];
    end
  end

  always_comb begin
    den      = 33'd65536 + {8'b0, rc} + {1'b0, cc};
    coef_num = {1'b1, 36'b0} + {5'b0, den[32:1]};
    if (cmd.div_coef) begin
      div_n = {coef_num, 1'b0};
      div_d = den;
    end else begin
      div_n = {freq, 23'b0};
      div_d = {15'b0, sample_rate_hz};
    end
  end

  hpb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .iters    (cmd.div_coef ? hpb_pkg::DIV_ITERS_COEF : hpb_pkg::DIV_ITERS_IDX),
    .busy     (div_busy),
    .quotient (quo)
  );

  hpb_tan_rom u_rom (
    .clk  (clk),
    .addr (idx),
    .data (c)
  );

  always_comb begin
    p_rnd   = p + 60'sd32768;
    acc_rnd = acc + 44'sd524288;
    y_wide  = acc_rnd[43:20];
    lim     = {9'b0, output_limit};
    if (y_wide > lim) begin
      y_next = lim[15:0];
    end else if (y_wide < -lim) begin
      y_next = -lim[15:0];
    end else begin
      y_next = y_wide[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 1'b1;
      last_mod <= '0;
    end else if (cfg_wr) begin
      pending <= 1'b1;
    end else if (cmd.load_in && sts.need_recompute) begin
      pending  <= 1'b0;
      last_mod <= cutoff_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
      a1 <= '0;
      b1 <= '0;
      b2 <= '0;
    end else begin
      if (cmd.ld_a1) begin
        a1 <= (quo > 38'd8388607) ? 24'sh7FFFFF : quo[23:0];
      end
      if (cmd.ld_b1) b1 <= sat_coef(p_rnd[59:16]);
      if (cmd.ld_b2) b2 <= sat_coef(p_rnd[59:16]);
      if (cmd.ld_out) begin
        x2 <= x1;
        x1 <= x;
        y2 <= y1;
        y1 <= y_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x    <= audio_in;
      modv <= cutoff_mod;
    end
    if (cmd.ld_freq) freq <= freq_next;
    if (cmd.ld_idx) idx <= (quo[37:10] != '0) ? 10'h3FF : quo[9:0];
    if (cmd.ld_rc) rc <= p[38:14];
    if (cmd.ld_cc) cc <= p[47:16];
    if (cmd.acc_init) begin
      acc <= p[43:0];
    end else if (cmd.acc_sub) begin
      acc <= acc - p[43:0];
    end
    if (cmd.ld_out) audio_out <= y_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_CHECK(a_out_load_free, clk, rst, cmd.ld_out |-> (!out_valid || !out_stall))
  `ASSERT_CHECK(a_div_start_idle, clk, rst, cmd.div_start |-> !div_busy)
  `ASSERT_NEXT(a_out_after_load, clk, rst, cmd.ld_out, out_valid)
  `ASSERT_CHECK(a_out_in_limit, clk, rst, out_valid |-> ($signed({audio_out[15], audio_out}) <= $signed({2'b0, output_limit}) && $signed({audio_out[15], audio_out}) >= -$signed({2'b0, output_limit})))

endmodule

// ===== sv/hpb_ctrl.sv =====
// Controller state machine: sequences coefficient recomputation and the
// filter evaluation over the datapath. Depends on hpb_pkg command types.
`timescale 1ns / 1ps
module hpb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hpb_pkg::hpb_sts_t sts,
  output hpb_pkg::hpb_cmd_t cmd
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_MAP   = 18'h00002,
    S_FREQ  = 18'h00004,
    S_DIVI  = 18'h00008,
    S_WAITI = 18'h00010,
    S_ROM   = 18'h00020,
    S_RC    = 18'h00040,
    S_CC    = 18'h00080,
    S_DEN   = 18'h00100,
    S_DIVA  = 18'h00200,
    S_WAITA = 18'h00400,
    S_B1    = 18'h00800,
    S_B2    = 18'h01000,
    S_B2W   = 18'h02000,
    S_F0    = 18'h04000,
    S_F1    = 18'h08000,
    S_F2    = 18'h10000,
    S_F3    = 18'h20000
  } state_t;

  state_t state, state_next;
  logic   out_wait;
  logic   out_done;

  assign in_stall = (state != S_IDLE) || out_wait;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = hpb_pkg::MUL_F0;
    case (state)
      S_IDLE: begin
        if (in_valid && !out_wait) begin
          cmd.load_in = 1'b1;
          state_next  = sts.need_recompute ? S_MAP : S_F0;
        end
      end
      S_MAP: begin
        cmd.mul_sel = hpb_pkg::MUL_MAP;
        state_next  = S_FREQ;
      end
      S_FREQ: begin
        cmd.ld_freq = 1'b1;
        state_next  = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAITI;
      end
      S_WAITI: begin
        if (!sts.div_busy) begin
          cmd.ld_idx = 1'b1;
          state_next = S_ROM;
        end
      end
      S_ROM: state_next = S_RC;
      S_RC: begin
        cmd.mul_sel = hpb_pkg::MUL_RC;
        state_next  = S_CC;
      end
      S_CC: begin
        cmd.ld_rc   = 1'b1;
        cmd.mul_sel = hpb_pkg::MUL_CC;
        state_next  = S_DEN;
      end
      S_DEN: begin
        cmd.ld_cc  = 1'b1;
        state_next = S_DIVA;
      end
      S_DIVA: begin
        cmd.div_start = 1'b1;
        cmd.div_coef  = 1'b1;
        state_next    = S_WAITA;
      end
      S_WAITA: begin
        cmd.div_coef = 1'b1;
        if (!sts.div_busy) begin
          cmd.ld_a1  = 1'b1;
          state_next = S_B1;
        end
      end
      S_B1: begin
        cmd.mul_sel = hpb_pkg::MUL_B1;
        state_next  = S_B2;
      end
      S_B2: begin
        cmd.ld_b1   = 1'b1;
        cmd.mul_sel = hpb_pkg::MUL_B2;
        state_next  = S_B2W;
      end
      S_B2W: begin
        cmd.ld_b2  = 1'b1;
        state_next = S_F0;
      end
      S_F0: begin
        cmd.mul_sel = hpb_pkg::MUL_F0;
        state_next  = S_F1;
      end
      S_F1: begin
        cmd.acc_init = 1'b1;
        cmd.mul_sel  = hpb_pkg::MUL_F1;
        state_next   = S_F2;
      end
      S_F2: begin
        cmd.acc_sub = 1'b1;
        cmd.mul_sel = hpb_pkg::MUL_F2;
        state_next  = S_F3;
      end
      S_F3: begin
        cmd.acc_sub = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // The result leaves from the accumulator as soon as the output register
    // is free; until then the next request is held off.
    cmd.ld_out = out_wait && sts.out_free;
  end

  assign out_done = (state == S_F3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_wait <= 1'b0;
    end else begin
      state <= state_next;
      if (out_done) begin
        out_wait <= 1'b1;
      end else if (sts.out_free) begin
        out_wait <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/modulated_highpass_biquad.sv =====
// Modulated high-pass biquad. A request is filtered with the stored coefficients
// when they stand, and after a recomputation of them when the modulation has
// changed or a register was written; that recomputation runs two serial divisions
// (26 and 37 steps). One request is in work at a time, so the next one waits until
// the result is loaded into the output register, which a stalled result holds off.
// Reset (synchronous, rst high) clears the filter state and coefficients,
// loads the register defaults and marks the coefficients for recomputation.
`timescale 1ns / 1ps
module modulated_highpass_biquad (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hpb_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [15:0]            audio_in,
  input  logic signed [15:0]            cutoff_mod,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            audio_out
);

  logic [14:0]        damping;
  logic signed [15:0] cutoff_offset_hz;
  logic [14:0]        min_frequency_hz;
  logic [14:0]        max_frequency_hz;
  logic [17:0]        sample_rate_hz;
  logic [14:0]        output_limit;
  logic               wr_en;
  logic               cfg_wr;
  logic [2:0]         reg_idx;

  hpb_pkg::hpb_cmd_t cmd;
  hpb_pkg::hpb_sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_wr  = wr_en && (reg_idx <= hpb_pkg::REG_OUT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      damping          <= 15'd23170;
      cutoff_offset_hz <= '0;
      min_frequency_hz <= 15'd20;
      max_frequency_hz <= 15'd20000;
      sample_rate_hz   <= 18'd44100;
      output_limit     <= 15'd32767;
    end else if (wr_en) begin
      case (reg_idx)
        hpb_pkg::REG_DAMPING:     damping          <= pwdata[14:0];
        hpb_pkg::REG_OFFSET:      cutoff_offset_hz <= pwdata[15:0];
        hpb_pkg::REG_MIN_FREQ:    min_frequency_hz <= pwdata[14:0];
        hpb_pkg::REG_MAX_FREQ:    max_frequency_hz <= pwdata[14:0];
        hpb_pkg::REG_SAMPLE_RATE: sample_rate_hz   <= pwdata[17:0];
        hpb_pkg::REG_OUT_LIMIT:   output_limit     <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      hpb_pkg::REG_DAMPING:     prdata = {17'b0, damping};
      hpb_pkg::REG_OFFSET:      prdata = {16'b0, cutoff_offset_hz};
      hpb_pkg::REG_MIN_FREQ:    prdata = {17'b0, min_frequency_hz};
      hpb_pkg::REG_MAX_FREQ:    prdata = {17'b0, max_frequency_hz};
      hpb_pkg::REG_SAMPLE_RATE: prdata = {14'b0, sample_rate_hz};
      hpb_pkg::REG_OUT_LIMIT:   prdata = {17'b0, output_limit};
      default:                  prdata = '0;
    endcase
  end

  hpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  hpb_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .audio_in         (audio_in),
    .cutoff_mod       (cutoff_mod),
    .cfg_wr           (cfg_wr),
    .damping          (damping),
    .cutoff_offset_hz (cutoff_offset_hz),
    .min_frequency_hz (min_frequency_hz),
    .max_frequency_hz (max_frequency_hz),
    .sample_rate_hz   (sample_rate_hz),
    .output_limit     (output_limit),
    .audio_out        (audio_out),
    .out_valid        (out_valid),
    .out_stall        (out_stall)
  );

endmodule

// ===== test/modulated_highpass_biquad_test.sv =====
// Self-checking testbench for the modulated high-pass biquad: drives audio and
// modulation requests, writes registers over APB and checks each filtered sample.
// Depends on hpb_pkg and the modulated_highpass_biquad RTL.
`timescale 1ns / 1ps
module modulated_highpass_biquad_test;

  localparam int IDLE_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [hpb_pkg::ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] audio_in;
  logic signed [15:0] cutoff_mod;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] audio_out;

  modulated_highpass_biquad dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .audio_in(audio_in),
    .cutoff_mod(cutoff_mod), .out_valid(out_valid), .out_stall(out_stall),
    .audio_out(audio_out)
  );

  // Predictor state.
  longint tan_lut [hpb_pkg::TAN_DEPTH];
  longint damp_r, offset_r, fmin_r, fmax_r, rate_r, limit_r;
  longint x1, x2, y1, y2, a1_c, b1_c, b2_c;
  logic signed [15:0] held_mod;
  bit coef_stale;

  logic [15:0] expected_samples [$];
  int mismatches;
  int checked;
  int sent;
  int recomputes;
  int idle_cycles;
  bit use_gaps;
  int burst_left;
  int hold_left;
  int hold_requests;
  int hold_served;
  int stall_mode;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic void build_tangents();
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint t;
    for (int k = 0; k < hpb_pkg::TAN_DEPTH; k++) begin
      z = (longint'(k) * hpb_pkg::PI_Q30) / (2 * hpb_pkg::TAN_DEPTH);
      x = 64'sd1 <<< 30;
      y = 0;
      for (int i = 0; i < hpb_pkg::CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= hpb_pkg::ATAN_Q30[i];
        end else begin
          x += dx; y -= dy; z += hpb_pkg::ATAN_Q30[i];
        end
      end
      if (y < 0) y = 0;
      if (x <= 0) t = hpb_pkg::TAN_MAX;
      else begin
        t = (y * 65536) / x;
        if (t > hpb_pkg::TAN_MAX) t = hpb_pkg::TAN_MAX;
      end
      tan_lut[k] = t;
    end
  endfunction

  function automatic longint clamp_coef(longint v);
    longint hi;
    hi = (64'sd1 <<< (hpb_pkg::COEF_FRAC + 3)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic logic [15:0] filter_sample(logic signed [15:0] x_in,
                                               logic signed [15:0] m_in);
    longint f;
    longint idx;
    longint q;
    longint c;
    longint one;
    longint rc;
    longint cc;
    longint den;
    longint a1;
    longint acc;
    longint y;
    longint lim;
    one = 64'sd1 <<< 16;
    if (coef_stale || m_in != held_mod) begin
      recomputes++;
      f = (((longint'(m_in) + 32768) * (fmax_r - fmin_r)) >>> 16) + fmin_r + offset_r;
      if (f < fmin_r) f = fmin_r;
      else if (f > fmax_r) f = fmax_r;
      idx = hpb_pkg::TAN_DEPTH - 1;
      if (rate_r != 0) begin
        q = f * 2 * hpb_pkg::TAN_DEPTH / rate_r;
        if (q < idx) idx = q;
      end
      c = tan_lut[idx];
      rc = (damp_r * c) >>> 14;
      cc = (c * c) >>> 16;
      den = one + rc + cc;
      a1 = ((64'sd1 <<< (16 + hpb_pkg::COEF_FRAC)) + den / 2) / den;
      a1_c = clamp_coef(a1);
      b1_c = clamp_coef((2 * (cc - one) * a1 + (64'sd1 <<< 15)) >>> 16);
      b2_c = clamp_coef(((one - rc + cc) * a1 + (64'sd1 <<< 15)) >>> 16);
      held_mod = m_in;
      coef_stale = 0;
    end
    acc = a1_c * x_in - 2 * a1_c * x1 + a1_c * x2 - b1_c * y1 - b2_c * y2;
    y = (acc + (64'sd1 <<< (hpb_pkg::COEF_FRAC - 1))) >>> hpb_pkg::COEF_FRAC;
    lim = (limit_r > 32767) ? 32767 : limit_r;
    if (y > lim) y = lim;
    if (y < -lim) y = -lim;
    x2 = x1;
    x1 = x_in;
    y2 = y1;
    y1 = y;
    return y[15:0];
  endfunction

  task automatic write_register(logic [2:0] index, logic [31:0] value);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    case (index)
      hpb_pkg::REG_DAMPING:     damp_r = longint'(value[14:0]);
      hpb_pkg::REG_OFFSET:      offset_r = longint'(signed'(value[15:0]));
      hpb_pkg::REG_MIN_FREQ:    fmin_r = longint'(value[14:0]);
      hpb_pkg::REG_MAX_FREQ:    fmax_r = longint'(value[14:0]);
      hpb_pkg::REG_SAMPLE_RATE: rate_r = longint'(value[17:0]);
      hpb_pkg::REG_OUT_LIMIT:   limit_r = longint'(value[14:0]);
      default: ;
    endcase
    coef_stale = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send_sample(logic signed [15:0] x, logic signed [15:0] m);
    @(negedge clk);
    in_valid = 1;
    audio_in = x;
    cutoff_mod = m;
    do @(posedge clk); while (in_stall);
    expected_samples.push_back(filter_sample(x, m));
    sent++;
    if (use_gaps) begin
      if (burst_left > 0) burst_left--;
      else begin
        @(negedge clk);
        in_valid = 0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
        burst_left = $urandom_range(0, 20);
      end
    end
  endtask

  // Waits until every expected sample is back and the block has gone quiet.
  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic test_defaults();
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd32767, 16'sd0);
    send_sample(-16'sd32768, 16'sd0);
    send_sample(16'sd1000, 16'sd0);
    send_sample(-16'sd1000, 16'sd32767);
    send_sample(16'sd32767, 16'sd32767);
    send_sample(-16'sd32768, -16'sd32768);
    send_sample(16'sd12345, -16'sd32768);
    send_sample(16'sd0, 16'sd1);
    send_sample(-16'sd1, -16'sd1);
    drain();
  endtask

  task automatic test_register_settings();
    logic [31:0] settings [10][6];
    settings = '{
      '{1638, 0, 20, 20000, 44100, 32767},
      '{23170, 24000, 20, 20000, 8000, 32767},
      '{23170, 32'hFFFF_A240, 1, 24000, 192000, 1000},
      '{32'hFFFF_7FFF, 0, 24000, 1, 44100, 0},
      '{5000, 100, 500, 500, 0, 32767},
      '{0, 32'h0001_8000, 32767, 32767, 32'hFFFC_0000, 32'h0000_FFFF},
      '{12000, 0, 1, 24000, 8000, 20000},
      '{1638, 32'hFFFF_FF00, 20, 20000, 192000, 32767},
      '{23170, 0, 0, 32767, 32'h0003_FFFF, 16384},
      '{23170, 0, 20, 20000, 48000, 32767}};
    for (int s = 0; s < 10; s++) begin
      write_register(hpb_pkg::REG_DAMPING, settings[s][0]);
      write_register(hpb_pkg::REG_OFFSET, settings[s][1]);
      write_register(hpb_pkg::REG_MIN_FREQ, settings[s][2]);
      write_register(hpb_pkg::REG_MAX_FREQ, settings[s][3]);
      write_register(hpb_pkg::REG_SAMPLE_RATE, settings[s][4]);
      write_register(hpb_pkg::REG_OUT_LIMIT, settings[s][5]);
      for (int i = 0; i < 12; i++)
        send_sample(16'($urandom), (i % 4 == 0) ? 16'($urandom) : 16'sd0);
      drain();
    end
  endtask

  task automatic test_backpressure();
    logic signed [15:0] m;
    m = 16'($urandom);
    hold_requests++;
    for (int i = 0; i < 40; i++)
      send_sample(16'($urandom), (i % 10 == 0) ? 16'($urandom) : m);
    drain();
  endtask

  // Mostly long runs with a steady modulation, since those keep the cached
  // coefficients in use, with frequent changes and full-range noise between.
  task automatic test_random(int count);
    logic signed [15:0] m;
    int run;
    run = 0;
    m = 0;
    for (int i = 0; i < count; i++) begin
      if (run == 0) begin
        m = 16'($urandom);
        run = $urandom_range(1, 25);
      end
      run--;
      if ($urandom_range(0, 9) == 0) send_sample(16'($urandom), 16'($urandom));
      else send_sample(16'($urandom), m);
      if (i % 400 == 399) begin
        drain();
        write_register(hpb_pkg::REG_DAMPING, $urandom_range(1638, 23170));
        write_register(hpb_pkg::REG_OFFSET, 32'($urandom_range(0, 48000)) - 32'd24000);
        write_register(hpb_pkg::REG_MIN_FREQ, $urandom_range(1, 2000));
        write_register(hpb_pkg::REG_MAX_FREQ, $urandom_range(2000, 24000));
        write_register(hpb_pkg::REG_SAMPLE_RATE, $urandom_range(8000, 192000));
        write_register(hpb_pkg::REG_OUT_LIMIT, $urandom_range(0, 32767));
        use_gaps = ($urandom_range(0, 3) != 0);
      end
    end
    drain();
  endtask

  // Receiver stall pattern, including a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rst) out_stall <= 0;
    else if (hold_left > 0) begin
      out_stall <= 1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", audio_out);
      end else begin
        logic [15:0] want;
        want = expected_samples.pop_front();
        checked++;
        if (audio_out !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("audio_out mismatch: expected %0d got %0d", $signed(want), audio_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; audio_in = 0; cutoff_mod = 0;
    sent = 0; recomputes = 0;
    use_gaps = 0; burst_left = 0;
    damp_r = 23170; offset_r = 0; fmin_r = 20; fmax_r = 20000;
    rate_r = 44100; limit_r = 32767;
    x1 = 0; x2 = 0; y1 = 0; y2 = 0; a1_c = 0; b1_c = 0; b2_c = 0;
    held_mod = 0; coef_stale = 1;
    build_tangents();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_defaults();
    use_gaps = 1;
    test_register_settings();
    test_backpressure();
    test_random(1750);
    $display("Sent %0d requests over many register settings, %0d checked samples,",
             sent, checked);
    $display("%0d coefficient recomputations, %0d mismatches.", recomputes, mismatches);
    if (mismatches == 0 && expected_samples.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== modulated_highpass_biquad.f =====
+incdir+sv
sv/hpb_pkg.sv
sv/hpb_tan_rom.sv
sv/hpb_div.sv
sv/hpb_dp.sv
sv/hpb_ctrl.sv
sv/modulated_highpass_biquad.sv
test/modulated_highpass_biquad_test.sv
